// ===== rtl/wsd_pkg.sv =====
// Shared types and constants for the WebSocket frame deframer.
// Depends on nothing; used by every module of the block except wsd_in_reg.
`default_nettype none

package wsd_pkg;

  // Parse phases
  typedef enum logic [2:0] {
    PH_HDR0   = 3'd0,
    PH_HDR1   = 3'd1,
    PH_EXT    = 3'd2,
    PH_MASK   = 3'd3,
    PH_PAY    = 3'd4,
    PH_CLOSED = 3'd5
  } phase_t;

  // Result kinds, plus the internal drop class
  localparam logic [2:0] KIND_TEXT      = 3'd0;
  localparam logic [2:0] KIND_BINARY    = 3'd1;
  localparam logic [2:0] KIND_PING      = 3'd2;
  localparam logic [2:0] KIND_CLOSE     = 3'd3;
  localparam logic [2:0] KIND_PROTO_ERR = 3'd4;
  localparam logic [2:0] KIND_TOO_LARGE = 3'd5;
  localparam logic [2:0] CLS_DROP       = 3'd6;

  // Opcodes
  localparam logic [3:0] OP_CONT     = 4'h0;
  localparam logic [3:0] OP_TEXT     = 4'h1;
  localparam logic [3:0] OP_BIN      = 4'h2;
  localparam logic [3:0] OP_SHUTDOWN = 4'h8;
  localparam logic [3:0] OP_PING     = 4'h9;
  localparam logic [3:0] OP_PONG     = 4'hA;

  // Open message type
  localparam logic [1:0] MT_NONE = 2'd0;
  localparam logic [1:0] MT_TEXT = 2'd1;
  localparam logic [1:0] MT_BIN  = 2'd2;

  // Header length codes
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;

  localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd33554432;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       message_start;
    logic       frame_last;
    logic       message_last;
  } wsd_result_t;

endpackage

`default_nettype wire

// ===== rtl/wsd_in_reg.sv =====
// Input register stage: holds one received byte until the parser takes it.
// Depends on nothing; the top level drives take from the parser's fire.
`default_nettype none

module wsd_in_reg (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] in_rx_byte,
  input  wire logic       take,
  output logic            byte_valid,
  output logic [7:0]      byte_data
);

  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;

  assign in_ready   = !valid_r || take;
  assign byte_valid = valid_r;
  assign byte_data  = byte_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wsd_parser.sv =====
// Frame parser: header, extended length, mask key and payload state plus
// the combinational result logic. Depends on wsd_pkg.
`default_nettype none

module wsd_parser #(
  parameter int LENGTH_WIDTH = 64
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               fire,
  input  wire logic [7:0]         rx_byte,
  input  wire logic [31:0]        max_payload_len,
  output logic                    res_valid,
  output wsd_pkg::wsd_result_t    res
);
  import wsd_pkg::*;

  localparam int LW    = LENGTH_WIDTH;
  localparam int CMP_W = (LW > 32) ? LW : 32;

  phase_t          phase_r, phase_nxt;
  logic            fin_r, fin_nxt;
  logic [3:0]      op_r, op_nxt;
  logic            masked_r, masked_nxt;
  logic [LW-1:0]   len_r, len_nxt;
  logic [3:0]      ext_left_r, ext_left_nxt;
  logic [31:0]     key_r, key_nxt;
  logic [1:0]      mpos_r, mpos_nxt;
  logic [1:0]      mtype_r, mtype_nxt;
  logic            frp_r, frp_nxt;

  logic [2:0]      cls;
  logic            end_hdr, end_frm, last, frp_hdr;
  logic [7:0]      key_byte;
  logic [CMP_W-1:0] max_cmp;

  // Class of the current frame from registered opcode and open message
  always_comb begin
    unique case (op_r)
      OP_CONT: begin
        if (mtype_r == MT_TEXT) begin
          cls = KIND_TEXT;
        end else if (mtype_r == MT_BIN) begin
          cls = KIND_BINARY;
        end else begin
          cls = CLS_DROP;
        end
      end
      OP_TEXT:     cls = KIND_TEXT;
      OP_BIN:      cls = KIND_BINARY;
      OP_SHUTDOWN: cls = KIND_CLOSE;
      OP_PING:     cls = KIND_PING;
      OP_PONG:     cls = CLS_DROP;
      default:     cls = KIND_PROTO_ERR;
    endcase
  end

  always_comb begin
    unique case (mpos_r)
      2'd0:    key_byte = key_r[31:24];
      2'd1:    key_byte = key_r[23:16];
      2'd2:    key_byte = key_r[15:8];
      default: key_byte = key_r[7:0];
    endcase
  end

  assign max_cmp = CMP_W'(max_payload_len);
  assign frp_hdr = (op_r == OP_TEXT) || (op_r == OP_BIN) ||
                   (op_r == OP_SHUTDOWN) || (op_r == OP_PING);

  always_comb begin
    phase_nxt    = phase_r;
    fin_nxt      = fin_r;
    op_nxt       = op_r;
    masked_nxt   = masked_r;
    len_nxt      = len_r;
    ext_left_nxt = ext_left_r;
    key_nxt      = key_r;
    mpos_nxt     = mpos_r;
    mtype_nxt    = mtype_r;
    frp_nxt      = frp_r;
    end_hdr      = 1'b0;
    end_frm      = 1'b0;
    last         = 1'b0;
    res_valid    = 1'b0;
    res          = '0;

    unique case (phase_r)
      PH_HDR0: begin
        fin_nxt   = rx_byte[7];
        op_nxt    = rx_byte[3:0];
        phase_nxt = PH_HDR1;
      end
      PH_HDR1: begin
        masked_nxt = rx_byte[7];
        key_nxt    = '0;
        mpos_nxt   = '0;
        if (rx_byte[6:0] == LEN7_EXT16 || rx_byte[6:0] == LEN7_EXT64) begin
          ext_left_nxt = (rx_byte[6:0] == LEN7_EXT16) ? 4'd2 : 4'd8;
          len_nxt      = '0;
          phase_nxt    = PH_EXT;
        end else begin
          len_nxt = LW'(rx_byte[6:0]);
          if (rx_byte[7]) begin
            phase_nxt = PH_MASK;
          end else begin
            end_hdr = 1'b1;
          end
        end
      end
      PH_EXT: begin
        // saturate once the top byte would shift out
        if (len_r[LW-1 -: 8] != '0) begin
          len_nxt = '1;
        end else begin
          len_nxt = {len_r[LW-9:0], rx_byte};
        end
        ext_left_nxt = ext_left_r - 4'd1;
        if (ext_left_nxt == '0) begin
          if (masked_r) begin
            phase_nxt = PH_MASK;
          end else begin
            end_hdr = 1'b1;
          end
        end
      end
      PH_MASK: begin
        key_nxt = {key_r[23:0], rx_byte};
        if (mpos_r != 2'd3) begin
          mpos_nxt = mpos_r + 2'd1;
        end else begin
          end_hdr = 1'b1;
        end
      end
      PH_PAY: begin
        mpos_nxt = mpos_r + 2'd1;
        len_nxt  = len_r - LW'(1);
        last     = (len_r == LW'(1));
        if (cls < KIND_PROTO_ERR) begin
          res_valid = 1'b1;
          res       = '{kind: cls, data_byte: rx_byte ^ key_byte, has_byte: 1'b1,
                        message_start: frp_r, frame_last: last,
                        message_last: last & fin_r};
          frp_nxt   = 1'b0;
        end
        end_frm = last;
      end
      default: begin
        // closed: ignore
      end
    endcase

    if (end_hdr) begin
      if (CMP_W'(len_nxt) > max_cmp) begin
        phase_nxt = PH_CLOSED;
        res_valid = 1'b1;
        res       = '{kind: KIND_TOO_LARGE, data_byte: 8'h00, has_byte: 1'b0,
                      message_start: 1'b1, frame_last: 1'b1, message_last: 1'b1};
      end else begin
        if (op_r == OP_TEXT || op_r == OP_BIN) begin
          mtype_nxt = fin_r ? MT_NONE : op_r[1:0];
        end
        frp_nxt  = frp_hdr;
        mpos_nxt = '0;
        if (len_nxt != '0) begin
          phase_nxt = PH_PAY;
        end else begin
          if (cls < KIND_PROTO_ERR) begin
            res_valid = 1'b1;
            res       = '{kind: cls, data_byte: 8'h00, has_byte: 1'b0,
                          message_start: frp_hdr, frame_last: 1'b1,
                          message_last: fin_r};
            frp_nxt   = 1'b0;
          end
          end_frm = 1'b1;
        end
      end
    end

    if (end_frm) begin
      if (cls == KIND_PROTO_ERR) begin
        phase_nxt = PH_CLOSED;
        res_valid = 1'b1;
        res       = '{kind: KIND_PROTO_ERR, data_byte: 8'h00, has_byte: 1'b0,
                      message_start: 1'b1, frame_last: 1'b1, message_last: 1'b1};
      end else begin
        if (op_r == OP_CONT && fin_r) begin
          mtype_nxt = MT_NONE;
        end
        phase_nxt = (op_r == OP_SHUTDOWN) ? PH_CLOSED : PH_HDR0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_HDR0;
      fin_r      <= 1'b0;
      op_r       <= OP_CONT;
      masked_r   <= 1'b0;
      len_r      <= '0;
      ext_left_r <= '0;
      key_r      <= '0;
      mpos_r     <= '0;
      mtype_r    <= MT_NONE;
      frp_r      <= 1'b0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      fin_r      <= fin_nxt;
      op_r       <= op_nxt;
      masked_r   <= masked_nxt;
      len_r      <= len_nxt;
      ext_left_r <= ext_left_nxt;
      key_r      <= key_nxt;
      mpos_r     <= mpos_nxt;
      mtype_r    <= mtype_nxt;
      frp_r      <= frp_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/wsd_out_reg.sv =====
// Result register: holds one result until the receiver takes it.
// Depends on wsd_pkg for the result struct.
`default_nettype none

module wsd_out_reg (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 load,
  input  wire logic                 load_valid,
  input  wire wsd_pkg::wsd_result_t load_res,
  output logic                      free,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output wsd_pkg::wsd_result_t      out_res
);
  import wsd_pkg::*;

  logic        valid_r, valid_nxt;
  wsd_result_t res_r;

  assign free      = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = load_valid;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/websocket_frame_deframer.sv =====
// WebSocket receive-side frame deframer, top level.
// Depends on wsd_pkg, wsd_in_reg, wsd_parser and wsd_out_reg.
//
// Usage:
// - in_*: one received byte per request (in_rx_byte), valid/ready.
// - out_*: zero or one result per byte: kind, unmasked data_byte, has_byte,
//   message_start, frame_last, message_last; valid/ready.
// - cfg_*: writes max_payload_len (reset 32 MiB); cfg_ready is always high.
//   Write only while the block is idle.
// - Path: an accepted byte waits in the input register and is parsed, with
//   any result loaded into the output register, whenever the output
//   register is free.
// - Throughput: one byte per cycle while out_ready keeps up; the header,
//   length, mask and payload state update in the single parser stage
//   between the input and result registers.
// - Stall: while a result waits on out_ready, one more byte is still taken
//   into the input register; then in_ready drops until the result leaves.
// - Reset (rst_n low, synchronous): parser waits for the first header byte,
//   no message open, both stages empty, max_payload_len back to default.
// - After a close frame or an error result all further bytes are taken and
//   ignored until reset.
`default_nettype none

module websocket_frame_deframer #(
  parameter int LENGTH_WIDTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [7:0]       out_data_byte,
  output logic             out_has_byte,
  output logic             out_message_start,
  output logic             out_frame_last,
  output logic             out_message_last,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [31:0] cfg_max_payload_len
);
  import wsd_pkg::*;

  logic [31:0] max_payload_r;
  logic        byte_valid, out_free, fire, res_valid;
  logic [7:0]  byte_data;
  wsd_result_t res, out_res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_payload_r <= MAX_PAYLOAD_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_payload_r <= cfg_max_payload_len;
    end
  end

  // A byte is parsed only when the result register can take its result.
  assign fire = byte_valid && out_free;

  wsd_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_rx_byte (in_rx_byte),
    .take       (fire),
    .byte_valid (byte_valid),
    .byte_data  (byte_data)
  );

  wsd_parser #(
    .LENGTH_WIDTH (LENGTH_WIDTH)
  ) u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .fire            (fire),
    .rx_byte         (byte_data),
    .max_payload_len (max_payload_r),
    .res_valid       (res_valid),
    .res             (res)
  );

  wsd_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire),
    .load_valid (res_valid),
    .load_res   (res),
    .free       (out_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_res    (out_res)
  );

  assign out_kind          = out_res.kind;
  assign out_data_byte     = out_res.data_byte;
  assign out_has_byte      = out_res.has_byte;
  assign out_message_start = out_res.message_start;
  assign out_frame_last    = out_res.frame_last;
  assign out_message_last  = out_res.message_last;

`ifndef SYNTHESIS
  // Only defined kinds leave the block.
  a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_kind <= KIND_TOO_LARGE))
    else $error("result kind out of range");

  // Error results carry no byte and end frame and message.
  a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == KIND_PROTO_ERR || out_kind == KIND_TOO_LARGE)
    |-> (!out_has_byte && out_message_start && out_frame_last && out_message_last))
    else $error("malformed error result");

  // message_last only on the last result of a frame.
  a_msg_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_last |-> out_frame_last)
    else $error("message_last without frame_last");

  // Once an error result is taken the block is closed and stays silent.
  a_closed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready &&
    (out_kind == KIND_PROTO_ERR || out_kind == KIND_TOO_LARGE) |=> !out_valid)
    else $error("result after error");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/websocket_frame_deframer_test.sv =====
// Self-checking testbench for websocket_frame_deframer: random WebSocket byte
// streams against an in-bench deframer model, valid/ready with random stalls.
// Depends on wsd_pkg and the websocket_frame_deframer RTL.
`timescale 1ns / 1ps

module websocket_frame_deframer_test;
  import wsd_pkg::*;

  // Mirrors the DUT's default length width.
  localparam int LW = 64;
  localparam logic [63:0] LEN_MASK = {64{1'b1}} >> (64 - LW);

  // How the payload length is carried in the header.
  typedef enum int {LEN_SHORT, LEN_EXT16, LEN_EXT64} len_form_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_rx_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_data_byte;
  logic        out_has_byte;
  logic        out_message_start;
  logic        out_frame_last;
  logic        out_message_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_max_payload_len = 32'h0;

  websocket_frame_deframer dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_kind            (out_kind),
    .out_data_byte       (out_data_byte),
    .out_has_byte        (out_has_byte),
    .out_message_start   (out_message_start),
    .out_frame_last      (out_frame_last),
    .out_message_last    (out_message_last),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_max_payload_len (cfg_max_payload_len)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Deframer model state. Starts at the post-reset values; reset is applied
  // only once, so no separate model reset is needed.
  // ---------------------------------------------------------------------------
  phase_t      ps_phase = PH_HDR0;
  logic        fr_fin = 1'b0;
  logic [3:0]  fr_op = OP_CONT;
  logic        fr_masked = 1'b0;
  logic [63:0] len_left = '0;       // remaining payload bytes / length being built
  logic [3:0]  ext_left = '0;       // extended length bytes still to come
  logic [31:0] mkey = '0;
  logic [1:0]  mpos = '0;
  logic [1:0]  msg_type = MT_NONE;  // type of the open fragmented message
  logic        first_pending = 1'b0;
  logic [31:0] max_len = MAX_PAYLOAD_RESET;

  // Traffic bookkeeping
  logic [7:0]  rx_backlog[$];       // bytes waiting to be driven
  wsd_result_t pending_results[$];  // predicted results, oldest first
  int unsigned bytes_queued = 0;
  int unsigned bytes_taken = 0;
  int          mismatches = 0;
  int          in_gap = 0;
  int          in_quiet = 0;
  int          out_stall = 0;
  int          out_quiet = 0;

  // Result kind of the current frame; CLS_DROP for pong and orphan
  // continuations, KIND_PROTO_ERR for reserved opcodes.
  function automatic logic [2:0] frame_kind();
    case (fr_op)
      OP_CONT: begin
        if (msg_type == MT_TEXT) return KIND_TEXT;
        if (msg_type == MT_BIN) return KIND_BINARY;
        return CLS_DROP;
      end
      OP_TEXT:     return KIND_TEXT;
      OP_BIN:      return KIND_BINARY;
      OP_SHUTDOWN: return KIND_CLOSE;
      OP_PING:     return KIND_PING;
      OP_PONG:     return CLS_DROP;
      default:     return KIND_PROTO_ERR;
    endcase
  endfunction

  // Error results differ only in kind, and they close the stream.
  function automatic wsd_result_t close_on_error(input logic [2:0] kind);
    ps_phase = PH_CLOSED;
    return '{kind, 8'h00, 1'b0, 1'b1, 1'b1, 1'b1};
  endfunction

  // After the last payload byte, or right at the header end of an empty frame.
  function automatic void frame_done(input logic [2:0] cls, inout bit got,
                                     inout wsd_result_t res);
    if (cls == KIND_PROTO_ERR) begin
      got = 1'b1;
      res = close_on_error(KIND_PROTO_ERR);
    end else begin
      if (fr_op == OP_CONT && fr_fin) msg_type = MT_NONE;
      ps_phase = (fr_op == OP_SHUTDOWN) ? PH_CLOSED : PH_HDR0;
    end
  endfunction

  function automatic void header_done(inout bit got, inout wsd_result_t res);
    logic [2:0] cls;
    // Size check comes first, so pong and orphan frames are checked too.
    if (len_left > 64'(max_len)) begin
      got = 1'b1;
      res = close_on_error(KIND_TOO_LARGE);
      return;
    end
    cls = frame_kind();
    if (fr_op == OP_TEXT || fr_op == OP_BIN)
      msg_type = fr_fin ? MT_NONE : ((fr_op == OP_TEXT) ? MT_TEXT : MT_BIN);
    first_pending = (fr_op == OP_TEXT || fr_op == OP_BIN ||
                     fr_op == OP_SHUTDOWN || fr_op == OP_PING);
    mpos = '0;
    if (len_left != 0) begin
      ps_phase = PH_PAY;
      return;
    end
    // Empty frame: one result without a data byte.
    if (cls < KIND_PROTO_ERR) begin
      got = 1'b1;
      res = '{cls, 8'h00, 1'b0, first_pending, 1'b1, fr_fin};
      first_pending = 1'b0;
    end
    frame_done(cls, got, res);
  endfunction

  // Advances the model by one received byte; returns 1 when a result is due.
  function automatic bit deframe_byte(input logic [7:0] b, output wsd_result_t res);
    logic [2:0] cls;
    logic [7:0] key;
    bit         got;
    bit         last;
    got = 1'b0;
    res = '0;
    case (ps_phase)
      PH_HDR0: begin
        fr_fin = b[7];
        fr_op = b[3:0];
        ps_phase = PH_HDR1;
      end
      PH_HDR1: begin
        fr_masked = b[7];
        mkey = '0;
        mpos = '0;
        if (b[6:0] == LEN7_EXT16 || b[6:0] == LEN7_EXT64) begin
          ext_left = (b[6:0] == LEN7_EXT16) ? 4'd2 : 4'd8;
          len_left = '0;
          ps_phase = PH_EXT;
        end else begin
          len_left = 64'(b[6:0]);
          if (fr_masked) ps_phase = PH_MASK;
          else header_done(got, res);
        end
      end
      PH_EXT: begin
        // saturate when the next byte would not fit
        if (len_left > (LEN_MASK >> 8)) len_left = LEN_MASK;
        else len_left = ((len_left << 8) | 64'(b)) & LEN_MASK;
        ext_left = ext_left - 4'd1;
        if (ext_left == 0) begin
          if (fr_masked) ps_phase = PH_MASK;
          else header_done(got, res);
        end
      end
      PH_MASK: begin
        mkey = {mkey[23:0], b};
        if (mpos != 2'd3) mpos = mpos + 2'd1;
        else header_done(got, res);
      end
      PH_PAY: begin
        cls = frame_kind();
        key = mkey[8 * (3 - int'(mpos)) +: 8];
        mpos = mpos + 2'd1;
        len_left = (len_left - 64'd1) & LEN_MASK;
        last = (len_left == 0);
        if (cls < KIND_PROTO_ERR) begin
          got = 1'b1;
          res = '{cls, b ^ key, 1'b1, first_pending, last, last & fr_fin};
          first_pending = 1'b0;
        end
        if (last) frame_done(cls, got, res);
      end
      default: ;  // closed: bytes are swallowed
    endcase
    return got;
  endfunction

  // Per-request wait, drawn at random, with occasional back-to-back stretches.
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 24) == 0) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    return $urandom_range(0, 12);
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: takes bytes from the backlog. Prediction happens at the accepting
  // edge, so the model sees exactly the bytes the DUT took, in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : drive_rx
    wsd_result_t res;
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        if (deframe_byte(in_rx_byte, res))
          pending_results.insert(pending_results.size(), res);
        bytes_taken++;  // after the push, so waiters see both or neither
        in_gap = draw_wait(in_quiet);
      end
      if (in_valid && !in_ready) begin
        // request still waiting: hold valid and byte
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (rx_backlog.size() != 0) begin
        in_valid <= 1'b1;
        in_rx_byte <= rx_backlog.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random backpressure, every accepted result checked in order.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch_results
    wsd_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with none pending: kind %0d data %0h", out_kind, out_data_byte);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", 8'(want.kind), 8'(out_kind));
          check_field("data_byte", want.data_byte, out_data_byte);
          check_field("has_byte", 8'(want.has_byte), 8'(out_has_byte));
          check_field("message_start", 8'(want.message_start), 8'(out_message_start));
          check_field("frame_last", 8'(want.frame_last), 8'(out_frame_last));
          check_field("message_last", 8'(want.message_last), 8'(out_message_last));
        end
        out_stall = draw_wait(out_quiet);
      end
      if (out_stall > 0) begin
        out_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic put_byte(input logic [7:0] b);
    rx_backlog.insert(rx_backlog.size(), b);
    bytes_queued++;
  endtask

  // RSV bits are random: the block ignores them.
  task automatic put_header(input bit fin, input logic [3:0] op, input bit masked,
                            input len_form_t form, input logic [63:0] len);
    put_byte({fin, 3'($urandom_range(0, 7)), op});
    case (form)
      LEN_SHORT: put_byte({masked, len[6:0]});
      LEN_EXT16: begin
        put_byte({masked, LEN7_EXT16});
        put_byte(len[15:8]);
        put_byte(len[7:0]);
      end
      default: begin
        put_byte({masked, LEN7_EXT64});
        for (int i = 7; i >= 0; i--) put_byte(len[8 * i +: 8]);
      end
    endcase
    if (masked) repeat (4) put_byte(8'($urandom));
  endtask

  task automatic put_frame(input bit fin, input logic [3:0] op, input bit masked,
                           input len_form_t form, input int unsigned len);
    put_header(fin, op, masked, form, 64'(len));
    repeat (len) put_byte(8'($urandom));
  endtask

  // Short lengths also go out in the 16- and 64-bit forms (non-minimal encoding).
  function automatic len_form_t pick_form(input int unsigned len);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (len > 125) return (r < 12) ? LEN_EXT16 : LEN_EXT64;
    return (r < 12) ? LEN_SHORT : (r < 16) ? LEN_EXT16 : LEN_EXT64;
  endfunction

  // Well-formed frame that neither closes the stream nor exceeds cap.
  // Continuations are frequent so fragmented messages run several frames deep;
  // a fresh text/binary frame mid-message drops the open one.
  task automatic put_random_frame(input int unsigned cap);
    int unsigned r;
    int unsigned len;
    logic [3:0]  op;
    bit          fin;
    r = $urandom_range(0, 99);
    if (r < 35) op = OP_CONT;
    else if (r < 55) op = OP_TEXT;
    else if (r < 75) op = OP_BIN;
    else if (r < 90) op = OP_PING;
    else op = OP_PONG;
    if (op == OP_PING || op == OP_PONG) fin = ($urandom_range(0, 5) != 0);
    else fin = 1'($urandom_range(0, 1));
    r = $urandom_range(0, 19);
    if (r < 2) len = 0;
    else if (r < 16) len = $urandom_range(1, 12);
    else if (r < 19) len = $urandom_range(13, 60);
    else len = $urandom_range(126, 300);
    if (len > cap) len = cap;
    put_frame(fin, op, 1'($urandom_range(0, 1)), pick_form(len), len);
  endtask

  // Waits until the DUT has taken every byte and returned every result.
  task automatic drain();
    while (bytes_taken != bytes_queued || pending_results.size() != 0) @(posedge clk);
  endtask

  // Register write only while idle; the extra cycles cover a byte that is
  // still in the pipeline but produces no result.
  task automatic write_max_len(input logic [31:0] value);
    drain();
    repeat (4) @(posedge clk);
    cfg_max_payload_len <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    max_len = value;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [3:0]  op;
    int unsigned len;
    logic [63:0] big_len;

    // Directed part, default size limit.
    put_frame(1'b1, OP_TEXT, 1'b0, LEN_SHORT, 0);   // empty text
    put_frame(1'b0, OP_BIN, 1'b1, LEN_SHORT, 2);    // opens a masked binary message
    put_frame(1'b1, OP_PING, 1'b0, LEN_SHORT, 0);   // control frame inside it
    put_frame(1'b1, OP_CONT, 1'b0, LEN_EXT16, 1);   // closes it out, keeps binary
    put_frame(1'b1, OP_PONG, 1'b1, LEN_SHORT, 1);   // pong: swallowed
    put_frame(1'b1, OP_CONT, 1'b0, LEN_SHORT, 0);   // orphan continuation: swallowed
    put_frame(1'b0, OP_TEXT, 1'b0, LEN_SHORT, 1);   // text left open ...
    put_frame(1'b1, OP_BIN, 1'b0, LEN_EXT64, 1);    // ... dropped by a new message
    put_frame(1'b0, OP_PING, 1'b0, LEN_SHORT, 1);   // control frame with fin clear

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Zero limit: only empty frames are legal.
    write_max_len(32'h0000_0000);
    repeat (30) put_random_frame(0);

    // No limit: bulk traffic.
    write_max_len(32'hFFFF_FFFF);
    while (bytes_queued < 950) put_random_frame(32'hFFFF_FFFF);

    // Small limit: lengths at and just under the limit show up often.
    write_max_len($urandom_range(1, 20));
    while (bytes_queued < 1200) put_random_frame(max_len);

    // Closing event: exactly one per run, since reset is never reapplied.
    case ($urandom_range(0, 2))
      0: begin  // close frame
        len = $urandom_range(0, (max_len < 8) ? max_len : 8);
        put_frame(1'($urandom_range(0, 1)), OP_SHUTDOWN, 1'($urandom_range(0, 1)),
                  pick_form(len), len);
      end
      1: begin  // reserved opcode: payload eaten, then a protocol error
        op = 4'($urandom_range(0, 9));
        op = (op < 5) ? op + OP_BIN + 4'd1 : op - 4'd5 + OP_PONG + 4'd1;
        len = $urandom_range(0, max_len);
        put_frame(1'($urandom_range(0, 1)), op, 1'($urandom_range(0, 1)),
                  pick_form(len), len);
      end
      default: begin  // oversized header, any opcode
        op = 4'($urandom_range(0, 15));
        if ($urandom_range(0, 1) == 0) begin
          len = max_len + 1 + $urandom_range(0, 100);
          put_header(1'($urandom_range(0, 1)), op, 1'($urandom_range(0, 1)),
                     pick_form(len), 64'(len));
        end else begin
          big_len = {8'($urandom_range(1, 255)), 24'($urandom), 32'($urandom)};
          put_header(1'($urandom_range(0, 1)), op, 1'($urandom_range(0, 1)),
                     LEN_EXT64, big_len);
        end
      end
    endcase
    // Stream is closed now: these must all be ignored.
    repeat (3) put_random_frame(max_len);

    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run (~1300 bytes).
  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
